// File: design/staw_pkg.sv
// Shared constants, codes and payload types of the strided tensor axpby walker.
package staw_pkg;

	localparam int MAX_ORDER   = 8;
	localparam int EXTENT_BITS = 16;
	localparam int ADDR_BITS   = 32;
	localparam int VALUE_BITS  = 32;
	localparam int FRAC_BITS   = 16;

	localparam int DIM_W      = 3;   // dim_index field width
	localparam int DIMS_W     = 4;   // dims_in_use register width
	localparam int CMD_W      = 2;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int PROD_W = 2 * VALUE_BITS;
	localparam int SUM_W  = PROD_W + 2;
	localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) <<< (FRAC_BITS - 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_ELEM  = 2'd2
	} cmd_e;

	typedef enum logic [KIND_W-1:0] {
		KIND_ANNOUNCE = 2'd0,
		KIND_ELEM     = 2'd1,
		KIND_EMPTY    = 2'd2
	} kind_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHA = 2'd0,
		CFG_BETA  = 2'd1,
		CFG_DIMS  = 2'd2
	} cfg_idx_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_START,
		ST_MUL,
		ST_STEP,
		ST_EMIT
	} state_e;

	typedef struct packed {
		logic [CMD_W-1:0]              cmd;
		logic [DIM_W-1:0]              dim_index;
		logic [EXTENT_BITS-1:0]        extent;
		logic [ADDR_BITS-1:0]          stride_x;
		logic [ADDR_BITS-1:0]          stride_y;
		logic [ADDR_BITS-1:0]          stride_z;
		logic signed [VALUE_BITS-1:0]  x_value;
		logic signed [VALUE_BITS-1:0]  y_value;
	} item_t;

	typedef struct packed {
		kind_e                         kind;
		logic signed [VALUE_BITS-1:0]  z_value;
		logic [ADDR_BITS-1:0]          z_addr;
		logic [ADDR_BITS-1:0]          next_x_addr;
		logic [ADDR_BITS-1:0]          next_y_addr;
		logic                          last;
		logic                          saturated;
	} result_t;

	typedef struct packed {
		logic                   en;
		logic [CFG_IDX_W-1:0]   index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_wr_t;

	typedef struct packed {
		logic   capture;
		logic   load_entry;
		logic   start_clear;
		logic   elem_begin;
		logic   step;
		logic   out_load;
		kind_e  kind;
		logic   last;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic order_zero;
		logic carry;
		logic last_dim;
	} dp_stat_t;

endpackage

// File: design/staw_if.sv
// Channel interfaces of the walker: item input, result output, register writes.
interface staw_item_if import staw_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface staw_result_if import staw_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface staw_cfg_if import staw_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/strided_tensor_axpby_walker_core.sv
// Top level of the strided tensor axpby walker.
//
// Channels: item (sink) takes load, start and element commands; result (source)
// returns at most one result per item; cfg (sink) writes alpha_gain, beta_gain
// and dims_in_use and is always ready. Each transfer happens on valid && ready.
// One item is in work at a time; item.ready is high only while the sequencer idles.
// Steps per item, in order, from the accept up to the next possible accept:
//   load entry: capture, table write with the stride*extent back step
//   start walk: capture, clear and empty check, result register load
//   element:    capture, z address latch, a step for each dimension the odometer
//               touches (1..order, 1 at order zero), result register load; the
//               carry chain is stepped one dimension per cycle through one set of
//               pointer adders, in parallel with the two-stage multiplier
//   element while idle, unused command: capture only, no result
// A result appears on the cycle after its register load. The result register
// parts the two sides: the next item is accepted while a result waits, and the
// sequencer only holds in its emit step if a second result is ready before the
// receiver takes the first. Nothing is dropped or repeated under stalls.
// Reset clears gains to 1.0, order to zero, all tables, positions and pointers,
// and leaves the walker idle with no result pending.
module strided_tensor_axpby_walker_core import staw_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	staw_item_if.sink     item,
	staw_result_if.source result,
	staw_cfg_if.sink      cfg
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	cfg_wr_t  cfg_wr;
	logic     in_ready;
	logic     out_valid;
	result_t  res;

	// register writes must land only between items; the user keeps to this, the block does not enforce it; never hold them
	assign cfg.ready    = 1'b1;
	assign cfg_wr.en    = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data  = cfg.data;

	staw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_cmd    (item.data.cmd),
		.in_ready  (in_ready),
		.out_ready (result.ready),
		.out_valid (out_valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	staw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_data (item.data),
		.cfg_wr    (cfg_wr),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res)
	);

	assign item.ready   = in_ready;
	assign result.valid = out_valid;
	assign result.data  = res;

endmodule

// File: design/staw_axpby.sv
// Two-stage Q16.16 alpha*x + beta*y unit with rounding and saturation.
module staw_axpby import staw_pkg::*; (
	input  logic                          clk,
	input  logic signed [VALUE_BITS-1:0]  alpha,
	input  logic signed [VALUE_BITS-1:0]  beta,
	input  logic signed [VALUE_BITS-1:0]  x,
	input  logic signed [VALUE_BITS-1:0]  y,
	output logic signed [VALUE_BITS-1:0]  z,
	output logic                          sat
);

	logic signed [PROD_W-1:0] prod_a_s1;
	logic signed [PROD_W-1:0] prod_b_s1;
	logic signed [SUM_W-1:0]  sum;
	logic [SUM_W-FRAC_BITS-VALUE_BITS:0] top;
	logic                     fits;
	logic signed [VALUE_BITS-1:0] z_d;
	logic signed [VALUE_BITS-1:0] z_s2;
	logic                     sat_s2;

	always_ff @(posedge clk) begin
		prod_a_s1 <= alpha * x;
		prod_b_s1 <= beta * y;
	end

	always_comb begin
		sum  = SUM_W'(prod_a_s1) + SUM_W'(prod_b_s1) + ROUND_BIAS;
		// bits above the result's sign must all agree with it
		top  = sum[SUM_W-1:FRAC_BITS+VALUE_BITS-1];
		fits = (&top) | ~(|top);
		if (fits) begin
			z_d = sum[FRAC_BITS+VALUE_BITS-1:FRAC_BITS];
		end else if (sum[SUM_W-1]) begin
			z_d = {1'b1, {(VALUE_BITS-1){1'b0}}};
		end else begin
			z_d = {1'b0, {(VALUE_BITS-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		z_s2   <= z_d;
		sat_s2 <= ~fits;
	end

	assign z   = z_s2;
	assign sat = sat_s2;

endmodule

// File: design/staw_dp.sv
// Walker datapath: registers, dimension tables, odometer, pointers, result register.
module staw_dp import staw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  item_t     item_data,
	input  cfg_wr_t   cfg_wr,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	output result_t   res
);

	item_t                        item_q;
	logic signed [VALUE_BITS-1:0] alpha_q;
	logic signed [VALUE_BITS-1:0] beta_q;
	logic [DIMS_W-1:0]            dims_q;

	logic [EXTENT_BITS-1:0] ext_q [MAX_ORDER];
	logic [EXTENT_BITS-1:0] pos_q [MAX_ORDER];
	logic [ADDR_BITS-1:0]   sx_q  [MAX_ORDER];
	logic [ADDR_BITS-1:0]   sy_q  [MAX_ORDER];
	logic [ADDR_BITS-1:0]   sz_q  [MAX_ORDER];
	logic [ADDR_BITS-1:0]   bx_q  [MAX_ORDER];
	logic [ADDR_BITS-1:0]   by_q  [MAX_ORDER];
	logic [ADDR_BITS-1:0]   bz_q  [MAX_ORDER];

	logic [ADDR_BITS-1:0] ptr_x_q;
	logic [ADDR_BITS-1:0] ptr_y_q;
	logic [ADDR_BITS-1:0] ptr_z_q;
	logic [ADDR_BITS-1:0] zaddr_q;
	logic [DIM_W-1:0]     d_q;
	result_t              res_q;

	logic [DIMS_W-1:0]      order;
	logic                   empty;
	logic [EXTENT_BITS-1:0] pos_inc;
	logic                   carry;
	logic                   last_dim;
	logic [ADDR_BITS-1:0]   back_x;
	logic [ADDR_BITS-1:0]   back_y;
	logic [ADDR_BITS-1:0]   back_z;
	logic [ADDR_BITS-1:0]   ext_a;
	logic signed [VALUE_BITS-1:0] z;
	logic                   sat;
	result_t                res_d;

	staw_axpby u_axpby (
		.clk   (clk),
		.alpha (alpha_q),
		.beta  (beta_q),
		.x     (item_q.x_value),
		.y     (item_q.y_value),
		.z     (z),
		.sat   (sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= VALUE_BITS'(65536);
			beta_q  <= VALUE_BITS'(65536);
			dims_q  <= '0;
		end else if (cfg_wr.en) begin
			unique case (cfg_wr.index)
				CFG_ALPHA: alpha_q <= cfg_wr.data[VALUE_BITS-1:0];
				CFG_BETA:  beta_q  <= cfg_wr.data[VALUE_BITS-1:0];
				CFG_DIMS:  dims_q  <= cfg_wr.data[DIMS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		order = (dims_q > DIMS_W'(MAX_ORDER)) ? DIMS_W'(MAX_ORDER) : dims_q;
		empty = 1'b0;
		for (int i = 0; i < MAX_ORDER; i++) begin
			if ((DIMS_W'(i) < order) && (ext_q[i] == '0)) begin
				empty = 1'b1;
			end
		end
		pos_inc  = pos_q[d_q] + EXTENT_BITS'(1);
		carry    = pos_inc >= ext_q[d_q];
		last_dim = (DIMS_W'(d_q) + DIMS_W'(1)) >= order;
		// a wrap steps by stride and takes back stride*extent in one add
		ext_a  = ADDR_BITS'(item_q.extent);
		back_x = item_q.stride_x - item_q.stride_x * ext_a;
		back_y = item_q.stride_y - item_q.stride_y * ext_a;
		back_z = item_q.stride_z - item_q.stride_z * ext_a;
	end

	assign stat.empty      = empty;
	assign stat.order_zero = (order == '0);
	assign stat.carry      = carry;
	assign stat.last_dim   = last_dim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ORDER; i++) begin
				ext_q[i] <= '0;
				sx_q[i]  <= '0;
				sy_q[i]  <= '0;
				sz_q[i]  <= '0;
				bx_q[i]  <= '0;
				by_q[i]  <= '0;
				bz_q[i]  <= '0;
			end
		end else if (cmd.load_entry && (DIMS_W'(item_q.dim_index) < DIMS_W'(MAX_ORDER))) begin
			ext_q[item_q.dim_index] <= item_q.extent;
			sx_q[item_q.dim_index]  <= item_q.stride_x;
			sy_q[item_q.dim_index]  <= item_q.stride_y;
			sz_q[item_q.dim_index]  <= item_q.stride_z;
			bx_q[item_q.dim_index]  <= back_x;
			by_q[item_q.dim_index]  <= back_y;
			bz_q[item_q.dim_index]  <= back_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ORDER; i++) begin
				pos_q[i] <= '0;
			end
			ptr_x_q <= '0;
			ptr_y_q <= '0;
			ptr_z_q <= '0;
			d_q     <= '0;
		end else if (cmd.start_clear) begin
			for (int i = 0; i < MAX_ORDER; i++) begin
				pos_q[i] <= '0;
			end
			ptr_x_q <= '0;
			ptr_y_q <= '0;
			ptr_z_q <= '0;
			d_q     <= '0;
		end else if (cmd.elem_begin) begin
			d_q <= '0;
		end else if (cmd.step) begin
			if (order == '0) begin
				ptr_x_q <= '0;
				ptr_y_q <= '0;
				ptr_z_q <= '0;
			end else if (carry) begin
				pos_q[d_q] <= '0;
				ptr_x_q    <= ptr_x_q + bx_q[d_q];
				ptr_y_q    <= ptr_y_q + by_q[d_q];
				ptr_z_q    <= ptr_z_q + bz_q[d_q];
				if (!last_dim) begin
					d_q <= d_q + DIM_W'(1);
				end
			end else begin
				pos_q[d_q] <= pos_inc;
				ptr_x_q    <= ptr_x_q + sx_q[d_q];
				ptr_y_q    <= ptr_y_q + sy_q[d_q];
				ptr_z_q    <= ptr_z_q + sz_q[d_q];
			end
		end
	end

	always_comb begin
		res_d      = '0;
		res_d.kind = cmd.kind;
		res_d.last = cmd.last;
		if (cmd.kind == KIND_ELEM) begin
			res_d.z_value     = z;
			res_d.z_addr      = zaddr_q;
			res_d.next_x_addr = ptr_x_q;
			res_d.next_y_addr = ptr_y_q;
			res_d.saturated   = sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item_data;
		end
		if (cmd.elem_begin) begin
			zaddr_q <= (order == '0) ? '0 : ptr_z_q;
		end
		if (cmd.out_load) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule

// File: design/staw_ctrl.sv
// Walker controller: command sequencing, walk flag and result handshake.
module staw_ctrl import staw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] in_cmd,
	output logic             in_ready,
	input  logic             out_ready,
	output logic             out_valid,
	input  dp_stat_t         stat,
	output dp_cmd_t          cmd
);

	state_e state_q, state_d;
	logic   walking_q, walking_d;
	kind_e  kind_q, kind_d;
	logic   last_q, last_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			walking_q   <= 1'b0;
			kind_q      <= KIND_ANNOUNCE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			walking_q   <= walking_d;
			kind_q      <= kind_d;
			last_q      <= last_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		logic done;
		done        = stat.order_zero | stat.carry;
		state_d     = state_q;
		walking_d   = walking_q;
		kind_d      = kind_q;
		last_d      = last_q;
		out_valid_d = out_valid_q & ~out_ready;
		cmd         = '0;
		cmd.kind    = kind_q;
		cmd.last    = last_q;
		in_ready    = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (in_cmd)
						CMD_LOAD:  state_d = ST_LOAD;
						CMD_START: state_d = ST_START;
						CMD_ELEM:  state_d = walking_q ? ST_MUL : ST_IDLE;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.load_entry = 1'b1;
				state_d        = ST_IDLE;
			end
			ST_START: begin
				cmd.start_clear = 1'b1;
				walking_d       = ~stat.empty;
				kind_d          = stat.empty ? KIND_EMPTY : KIND_ANNOUNCE;
				last_d          = stat.empty;
				state_d         = ST_EMIT;
			end
			ST_MUL: begin
				cmd.elem_begin = 1'b1;
				state_d        = ST_STEP;
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				if (stat.order_zero || !stat.carry || stat.last_dim) begin
					kind_d  = KIND_ELEM;
					last_d  = done;
					state_d = ST_EMIT;
					if (done) begin
						walking_d = 1'b0;
					end
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: tb/sv/strided_tensor_axpby_walker_core_tb.sv
// Self-checking testbench of the strided tensor axpby walker core.
`timescale 1ns / 100ps

module strided_tensor_axpby_walker_core_tb;
	import staw_pkg::*;

	// The item channel can carry the fourth command code, which the block must ignore.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int unsigned ITEM_TARGET   = 1050; // random items that do real work
	localparam int unsigned QUIET_FROM    = 920;  // no idling on either side from here on
	localparam int unsigned SETTLE_CYCLES = 16;   // longest item (element, order 8) plus margin
	localparam int unsigned TAIL_CYCLES   = 24;
	localparam int unsigned STALL_LIMIT   = 2000; // cycles without any transfer

	localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] Z_MAX    = SUM_W'(32'sh7FFF_FFFF);
	localparam logic signed [SUM_W-1:0] Z_MIN    = SUM_W'(32'sh8000_0000);

	logic clk = 1'b0;
	logic arst_n;

	staw_item_if   item_bus ();
	staw_result_if result_bus ();
	staw_cfg_if    cfg_bus ();

	strided_tensor_axpby_walker_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the walker: registers, dimension tables, odometer.
	// Updated at the edge where the matching transfer happens.
	// ------------------------------------------------------------------
	logic signed [VALUE_BITS-1:0] gain_a = 32'sd65536;
	logic signed [VALUE_BITS-1:0] gain_b = 32'sd65536;
	logic [DIMS_W-1:0]            dims_reg = '0;

	logic [EXTENT_BITS-1:0] ext_tab [MAX_ORDER] = '{default: '0};
	logic [ADDR_BITS-1:0]   sx_tab  [MAX_ORDER] = '{default: '0};
	logic [ADDR_BITS-1:0]   sy_tab  [MAX_ORDER] = '{default: '0};
	logic [ADDR_BITS-1:0]   sz_tab  [MAX_ORDER] = '{default: '0};
	logic [EXTENT_BITS-1:0] pos_tab [MAX_ORDER] = '{default: '0};
	logic [ADDR_BITS-1:0]   x_ptr = '0;
	logic [ADDR_BITS-1:0]   y_ptr = '0;
	logic [ADDR_BITS-1:0]   z_ptr = '0;
	bit                     walk_on = 1'b0;

	// Results the walker still owes, oldest first.
	result_t walker_out_due [$];

	int unsigned mismatches = 0;
	int unsigned items_done = 0;
	int unsigned idle_pct = 20;  // chance of a gap or stall burst, in percent
	bit          quiet_tail = 1'b0;

	// An order register above MAX_ORDER walks all MAX_ORDER dimensions.
	function automatic int unsigned active_order();
		return (dims_reg > MAX_ORDER) ? MAX_ORDER : int'(dims_reg);
	endfunction

	// alpha*x + beta*y with exact products, round half up, clip to 32 bits.
	function automatic logic signed [VALUE_BITS-1:0] scale_sum(
		input logic signed [VALUE_BITS-1:0] xv,
		input logic signed [VALUE_BITS-1:0] yv,
		output bit clipped
	);
		logic signed [SUM_W-1:0] acc;
		acc = gain_a * xv + gain_b * yv + HALF_LSB;
		acc = acc >>> FRAC_BITS;
		clipped = 1'b1;
		if (acc > Z_MAX)
			return 32'sh7FFF_FFFF;
		if (acc < Z_MIN)
			return 32'sh8000_0000;
		clipped = 1'b0;
		return acc[VALUE_BITS-1:0];
	endfunction

	// Step the odometer one element; return 1 when every dimension wrapped.
	function automatic bit odometer_step(input int unsigned ord);
		int unsigned d;
		for (d = 0; d < ord; d++) begin
			pos_tab[d] = pos_tab[d] + 1'b1;
			x_ptr += sx_tab[d];
			y_ptr += sy_tab[d];
			z_ptr += sz_tab[d];
			if (pos_tab[d] < ext_tab[d])
				return 1'b0;
			// carry: drop this dimension back to its start
			pos_tab[d] = '0;
			x_ptr -= sx_tab[d] * ADDR_BITS'(ext_tab[d]);
			y_ptr -= sy_tab[d] * ADDR_BITS'(ext_tab[d]);
			z_ptr -= sz_tab[d] * ADDR_BITS'(ext_tab[d]);
		end
		return 1'b1;
	endfunction

	// Apply one accepted item to the shadow walker; return 1 if it owes a result.
	function automatic bit walker_step(input item_t it, output result_t res);
		int unsigned ord;
		int unsigned d;
		bit          empty;
		bit          clipped;
		bit          done;
		logic signed [VALUE_BITS-1:0] zv;
		res = '0;
		ord = active_order();
		case (it.cmd)
			CMD_LOAD: begin
				ext_tab[it.dim_index] = it.extent;
				sx_tab[it.dim_index]  = it.stride_x;
				sy_tab[it.dim_index]  = it.stride_y;
				sz_tab[it.dim_index]  = it.stride_z;
				return 1'b0;
			end
			CMD_START: begin
				empty = 1'b0;
				for (d = 0; d < MAX_ORDER; d++)
					pos_tab[d] = '0;
				x_ptr = '0;
				y_ptr = '0;
				z_ptr = '0;
				for (d = 0; d < ord; d++)
					if (ext_tab[d] == '0)
						empty = 1'b1;
				walk_on = !empty;
				res.kind = empty ? KIND_EMPTY : KIND_ANNOUNCE;
				res.last = empty;
				return 1'b1;
			end
			CMD_ELEM: begin
				if (!walk_on)
					return 1'b0;
				zv = scale_sum(it.x_value, it.y_value, clipped);
				if (ord == 0) begin
					res.z_addr = '0;
					x_ptr = '0;
					y_ptr = '0;
					z_ptr = '0;
					done = 1'b1;
				end else begin
					res.z_addr = z_ptr;
					done = odometer_step(ord);
				end
				walk_on = !done;
				res.kind        = KIND_ELEM;
				res.z_value     = zv;
				res.next_x_addr = x_ptr;
				res.next_y_addr = y_ptr;
				res.last        = done;
				res.saturated   = clipped;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Item builders. Fields a command does not use carry random noise.
	// ------------------------------------------------------------------
	function automatic item_t cmd_item(input logic [CMD_W-1:0] c);
		item_t it;
		it.cmd       = c;
		it.dim_index = DIM_W'($urandom);
		it.extent    = EXTENT_BITS'($urandom);
		it.stride_x  = $urandom;
		it.stride_y  = $urandom;
		it.stride_z  = $urandom;
		it.x_value   = $urandom;
		it.y_value   = $urandom;
		return it;
	endfunction

	function automatic item_t load_item(
		input int unsigned d,
		input logic [EXTENT_BITS-1:0] ext,
		input logic [ADDR_BITS-1:0] sx,
		input logic [ADDR_BITS-1:0] sy,
		input logic [ADDR_BITS-1:0] sz
	);
		item_t it;
		it = cmd_item(CMD_LOAD);
		it.dim_index = DIM_W'(d);
		it.extent    = ext;
		it.stride_x  = sx;
		it.stride_y  = sy;
		it.stride_z  = sz;
		return it;
	endfunction

	function automatic item_t elem_item(input logic [31:0] xv, input logic [31:0] yv);
		item_t it;
		it = cmd_item(CMD_ELEM);
		it.x_value = xv;
		it.y_value = yv;
		return it;
	endfunction

	// Mostly tiny extents so walks finish; now and then an empty or a huge one.
	function automatic logic [EXTENT_BITS-1:0] extent_pick(input int unsigned ord);
		case ($urandom_range(0, 39))
			0: return '0;
			1: return '1;
			2: return EXTENT_BITS'($urandom);
			default: return (ord > 3) ? EXTENT_BITS'($urandom_range(1, 2))
				: EXTENT_BITS'($urandom_range(1, 4));
		endcase
	endfunction

	function automatic logic [ADDR_BITS-1:0] stride_pick();
		case ($urandom_range(0, 3))
			0: return ADDR_BITS'($urandom_range(0, 16));
			1: return '1 - ADDR_BITS'($urandom_range(0, 16));  // small backward step
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] value_pick();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] gain_pick();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'h0001_0000;
			4: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
			default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Mismatch report: print one line and count it.
	// ------------------------------------------------------------------
	task automatic flag_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		mismatches++;
		$display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
	endtask

	// ------------------------------------------------------------------
	// Item sender. Hold valid across back-to-back transfers; drop it only
	// for an idle burst. Predict at the edge where the transfer happens.
	// ------------------------------------------------------------------
	task automatic push_item(input item_t it);
		result_t     owed;
		int unsigned gap;
		bit          real_work;
		if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 13);
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.data  <= it;
		do @(posedge clk); while (item_bus.ready !== 1'b1);
		// idle elements and the unused code are merely ignored: leave them out of the count
		real_work = (it.cmd == CMD_LOAD) || (it.cmd == CMD_START)
			|| (it.cmd == CMD_ELEM && walk_on);
		if (walker_step(it, owed))
			walker_out_due.push_back(owed);
		if (real_work)
			items_done++;
	endtask

	// Register write: only with no item in flight. Drain owed results, then
	// give a load or an ignored element time to finish before the transfer.
	task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
		item_bus.valid <= 1'b0;
		while (walker_out_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		cfg_bus.valid <= 1'b0;
		case (idx)
			CFG_ALPHA: gain_a = val;
			CFG_BETA:  gain_b = val;
			CFG_DIMS:  dims_reg = val[DIMS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic random_reg_write();
		case ($urandom_range(0, 2))
			0: write_reg(CFG_ALPHA, gain_pick());
			1: write_reg(CFG_BETA, gain_pick());
			// order above range now and then; upper data bits are noise
			default: write_reg(CFG_DIMS, {28'($urandom), ($urandom_range(0, 7) == 0)
				? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8))});
		endcase
	endtask

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// Straight out of reset: gains 1.0, order zero, so a walk is one scalar.
	task automatic test_order_zero_scalar();
		push_item(cmd_item(CMD_START));
		push_item(elem_item(32'h7FFF_FFFF, 32'h7FFF_FFFF));  // sum clips high
		push_item(elem_item(32'h0001_0000, 32'h0000_8000));  // walk over: ignored
		push_item(cmd_item(CMD_UNUSED));
	endtask

	// Gain and operand extremes, and a rounding tie, on one-element walks.
	task automatic test_gain_extremes();
		write_reg(CFG_ALPHA, 32'h8000_0000);
		write_reg(CFG_BETA, 32'h8000_0000);
		push_item(cmd_item(CMD_START));
		push_item(elem_item(32'h8000_0000, 32'h8000_0000));  // two 2^62 products
		write_reg(CFG_ALPHA, 32'h7FFF_FFFF);
		write_reg(CFG_BETA, 32'h0000_0000);
		push_item(cmd_item(CMD_START));
		push_item(elem_item(32'h8000_0000, 32'h7FFF_FFFF));  // clips low
		write_reg(CFG_ALPHA, 32'h0001_0000);
		write_reg(CFG_BETA, 32'h0000_8000);
		push_item(cmd_item(CMD_START));
		push_item(elem_item(32'h0000_0003, 32'hFFFF_FFFF));  // 2.5 lsb rounds up to 3
	endtask

	// Empty walk from a zero extent, an ignored element, then a long walk
	// that the next test restarts before it ends.
	task automatic test_empty_and_restart();
		write_reg(CFG_DIMS, 32'd2);
		push_item(load_item(0, 16'hFFFF, 32'h0000_0004, 32'hFFFF_FFFC, 32'h0000_0001));
		push_item(load_item(1, 16'h0000, 32'h1000_0000, 32'h0000_0100, 32'hFFFF_FFFF));
		push_item(cmd_item(CMD_START));
		push_item(elem_item(32'h0001_0000, 32'h0001_0000));
		push_item(load_item(1, 16'h0001, 32'h1000_0000, 32'h0000_0100, 32'hFFFF_FFFF));
		push_item(cmd_item(CMD_START));
		push_item(elem_item(32'h0002_0000, 32'hFFFF_0000));
		push_item(elem_item(32'h7FFF_FFFF, 32'h8000_0000));
	endtask

	// Reload the tables mid-walk, restart, and walk a 2x2 tensor to its end
	// with strides that wrap the address space.
	task automatic test_full_walk();
		push_item(load_item(0, 16'd2, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001));
		push_item(load_item(1, 16'd2, 32'h0000_0010, 32'hFFFF_FFF0, 32'h7FFF_FFFF));
		push_item(cmd_item(CMD_START));
		repeat (4) push_item(elem_item(value_pick(), value_pick()));
	endtask

	// Order register above MAX_ORDER: all eight tables count, the unused ones are empty.
	task automatic test_order_above_range();
		write_reg(CFG_DIMS, 32'd15);
		push_item(cmd_item(CMD_START));
		write_reg(CFG_DIMS, 32'd9);
		push_item(cmd_item(CMD_START));
	endtask

	// ------------------------------------------------------------------
	// Random walks: mostly well-formed load/start/element runs with random
	// content, sprinkled with mid-walk reloads, register writes, unused
	// codes and stray elements.
	// ------------------------------------------------------------------
	task automatic test_random_walks();
		int unsigned ord;
		int unsigned d;
		int unsigned cap;
		int unsigned elems;
		items_done = 0;
		while (items_done < ITEM_TARGET) begin
			if (items_done >= QUIET_FROM)
				quiet_tail = 1'b1;
			case ($urandom_range(0, 3))
				0: idle_pct = 0;
				1: idle_pct = 10;
				2: idle_pct = 25;
				default: idle_pct = 50;
			endcase
			if ($urandom_range(0, 2) == 0)
				random_reg_write();
			ord = active_order();
			if ($urandom_range(0, 3) != 0) begin
				for (d = 0; d < MAX_ORDER; d++) begin
					if (d < ord)
						push_item(load_item(d, extent_pick(ord), stride_pick(),
							stride_pick(), stride_pick()));
					else if ($urandom_range(0, 5) == 0)
						push_item(load_item(d, EXTENT_BITS'($urandom), $urandom,
							$urandom, $urandom));
				end
			end
			push_item(cmd_item(CMD_START));
			// cap the walk: huge extents only get a partial walk before the next start
			cap = $urandom_range(1, 40);
			elems = 0;
			while (walk_on && elems < cap) begin
				case ($urandom_range(0, 29))
					0: push_item(cmd_item(CMD_UNUSED));
					1: push_item(load_item($urandom_range(0, MAX_ORDER - 1), extent_pick(ord),
						stride_pick(), stride_pick(), stride_pick()));
					2: random_reg_write();
					default: begin
						push_item(elem_item(value_pick(), value_pick()));
						elems++;
					end
				endcase
			end
			if ($urandom_range(0, 4) == 0)
				push_item(elem_item(value_pick(), value_pick()));
		end
	endtask

	// ------------------------------------------------------------------
	// Result receiver: ready drops in bursts of random length, never in the tail.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int unsigned hold;
		hold = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (quiet_tail) begin
				result_bus.ready <= 1'b1;
			end else if (hold != 0) begin
				hold--;
			end else if ($urandom_range(0, 99) < idle_pct / 3) begin
				hold = $urandom_range(0, 12);
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	// Compare each result transfer, field by field, with the oldest owed result.
	always @(posedge clk) begin : result_check
		result_t want;
		if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			if (walker_out_due.size() == 0) begin
				flag_mismatch("result with none owed", 32'h0, 32'(result_bus.data.kind));
			end else begin
				want = walker_out_due.pop_front();
				if (want.kind !== result_bus.data.kind)
					flag_mismatch("kind", 32'(want.kind), 32'(result_bus.data.kind));
				if (want.z_value !== result_bus.data.z_value)
					flag_mismatch("z_value", want.z_value, result_bus.data.z_value);
				if (want.z_addr !== result_bus.data.z_addr)
					flag_mismatch("z_addr", want.z_addr, result_bus.data.z_addr);
				if (want.next_x_addr !== result_bus.data.next_x_addr)
					flag_mismatch("next_x_addr", want.next_x_addr, result_bus.data.next_x_addr);
				if (want.next_y_addr !== result_bus.data.next_y_addr)
					flag_mismatch("next_y_addr", want.next_y_addr, result_bus.data.next_y_addr);
				if (want.last !== result_bus.data.last)
					flag_mismatch("last", 32'(want.last), 32'(result_bus.data.last));
				if (want.saturated !== result_bus.data.saturated)
					flag_mismatch("saturated", 32'(want.saturated), 32'(result_bus.data.saturated));
			end
		end
	end

	// Watchdog: end the run if no transfer happens on any channel for too long.
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1)
					|| (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
					|| (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL strided_tensor_axpby_walker_core");
		$finish;
	end

	// Sequence: reset once, directed tests, random walks, drain, verdict.
	initial begin
		arst_n         <= 1'b0;
		item_bus.valid <= 1'b0;
		item_bus.data  <= '0;
		cfg_bus.valid  <= 1'b0;
		cfg_bus.index  <= '0;
		cfg_bus.data   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_order_zero_scalar();
		test_gain_extremes();
		test_empty_and_restart();
		test_full_walk();
		test_order_above_range();
		test_random_walks();

		// hold the input quiet, wait for every owed result, then let the pipe settle
		item_bus.valid <= 1'b0;
		while (walker_out_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS strided_tensor_axpby_walker_core");
		else
			$display("FAIL strided_tensor_axpby_walker_core");
		$finish;
	end

endmodule
